// File: rtl/sgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgt_pkg
// Shared widths, defaults and types for the sequence gap tracker.
// ----------------------------------------------------------------------------
package sgt_pkg;

    // Field widths
    localparam int SRC_W = 32;
    localparam int SEQ_W = 64;

    // Default table depth
    localparam int SOURCES_DEFAULT = 16;

    // Table write controls for one packet
    typedef struct packed {
        logic raise;   // hit entry takes a new highest sequence
        logic insert;  // lowest free entry takes the source and sequence
    } sgt_wr_t;

    // Table lookup status
    typedef struct packed {
        logic hit;       // source present in the table
        logic has_free;  // at least one entry is unused
    } sgt_look_t;

endpackage

// File: rtl/sgt_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgt_table
// Source table: parallel key compare across all entries, lowest-free-entry
// search, highest-sequence readout for the hit entry, and entry update.
// ----------------------------------------------------------------------------
module sgt_table
    import sgt_pkg::*;
#(
    parameter int SOURCES = SOURCES_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SRC_W-1:0] stream_id,
    input  logic [SEQ_W-1:0] sequence_req,
    input  sgt_wr_t          wr,
    output sgt_look_t        look,
    output logic [SEQ_W-1:0] hit_highest
);

    logic [SOURCES-1:0] entry_valid_reg;
    logic [SOURCES-1:0] entry_valid_next;
    logic [SRC_W-1:0]   entry_source_reg  [SOURCES];
    logic [SEQ_W-1:0]   entry_highest_reg [SOURCES];

    logic [SOURCES-1:0] match;
    logic [SOURCES-1:0] hit_oh;
    logic [SOURCES-1:0] free_vec;
    logic [SOURCES-1:0] free_oh;
    logic [SEQ_W-1:0]   highest_mux;

    // Key compare per entry
    always_comb
    begin
        for (int i = 0; i < SOURCES; i++)
        begin
            match[i] = entry_valid_reg[i] && (entry_source_reg[i] == stream_id);
        end
    end

    // Lowest set bit of the match and free vectors
    assign free_vec = ~entry_valid_reg;
    assign hit_oh   = match & (~match + SOURCES'(1));
    assign free_oh  = free_vec & (~free_vec + SOURCES'(1));

    // Highest value of the hit entry
    always_comb
    begin
        highest_mux = '0;
        for (int i = 0; i < SOURCES; i++)
        begin
            if (hit_oh[i])
            begin
                highest_mux = highest_mux | entry_highest_reg[i];
            end
        end
    end

    assign look.hit      = |match;
    assign look.has_free = |free_vec;
    assign hit_highest   = highest_mux;

    // Valid marks
    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        if (wr.insert)
        begin
            entry_valid_next = entry_valid_reg | free_oh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
        end
    end

    // Entry payload, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SOURCES; i++)
        begin
            if (wr.insert && free_oh[i])
            begin
                entry_source_reg[i]  <= stream_id;
                entry_highest_reg[i] <= sequence_req;
            end
            else if (wr.raise && hit_oh[i])
            begin
                entry_highest_reg[i] <= sequence_req;
            end
        end
    end

endmodule

// File: rtl/sequence_gap_tracker_core.sv
`timescale 1ns / 1ps
// Path: input register, then result register. Throughput: one packet per
// cycle unless m_axis_tready stalls the result register; table lookup,
// compare and 64-bit subtract sit in one stage between the input and
// result registers.
// Reset: rst_n clears all valid marks and both pipeline valids at once.
// ----------------------------------------------------------------------------
// sequence_gap_tracker_core
// Per-source sequence loss detection: reports skipped sequence numbers,
// new sources, stale packets and table overflow, one result per packet.
// ----------------------------------------------------------------------------
module sequence_gap_tracker_core
    import sgt_pkg::*;
#(
    parameter int SOURCES = SOURCES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SRC_W+SEQ_W-1:0] s_axis_tdata,   // stream_id, sequence_req
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [SEQ_W-1:0]       m_axis_tdata,   // gap
    output logic [2:0]             m_axis_tuser    // new_source, stale, table_full
);

    logic             in_valid_reg;
    logic [SRC_W-1:0] in_src_reg;
    logic [SEQ_W-1:0] in_seq_reg;
    logic             out_valid_reg;
    logic [SEQ_W-1:0] out_gap_reg;
    logic [2:0]       out_flags_reg;

    logic             advance;
    sgt_wr_t          wr;
    sgt_look_t        look;
    logic [SEQ_W-1:0] hit_highest;
    logic             stale;
    logic             new_src;
    logic             full;
    logic [SEQ_W-1:0] gap;

    // Handshake: stage moves when the result slot is free or being taken
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_src_reg <= s_axis_tdata[SRC_W-1:0];
            in_seq_reg <= s_axis_tdata[SRC_W+SEQ_W-1:SRC_W];
        end
    end

    sgt_table #(
        .SOURCES (SOURCES)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_id    (in_src_reg),
        .sequence_req (in_seq_reg),
        .wr           (wr),
        .look         (look),
        .hit_highest  (hit_highest)
    );

    // Classify the packet and compute the gap
    always_comb
    begin
        stale     = look.hit && (in_seq_reg <= hit_highest);
        new_src   = !look.hit && look.has_free;
        full      = !look.hit && !look.has_free;
        wr.raise  = advance && look.hit && !stale;
        wr.insert = advance && new_src;
        gap       = '0;
        if (look.hit && !stale)
        begin
            gap = in_seq_reg - hit_highest - {{(SEQ_W-1){1'b0}}, 1'b1};
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_gap_reg   <= gap;
            out_flags_reg <= {full, stale, new_src};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_gap_reg;
    assign m_axis_tuser  = out_flags_reg;

endmodule

// File: tb/sequence_gap_tracker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_gap_tracker_core_test
// Self-checking bench for the sequence gap tracker. A directed table covers
// the corners: sequence extremes, duplicates, in-order packets, filling the
// source table and overflow. A random phase follows, built mostly from
// in-order, skipped and late packets on the stored sources. A behavioral
// copy of the source table predicts results without a known value. Random
// idle bursts are applied on both stream sides, except the last QUIET_ITEMS.
// ----------------------------------------------------------------------------
module sequence_gap_tracker_core_test
    import sgt_pkg::*;
();

    localparam int SOURCES       = SOURCES_DEFAULT;
    localparam int RANDOM_ITEMS  = 1075;
    localparam int QUIET_ITEMS   = 150;
    localparam int DRAIN_PAUSE_AT = 500;
    localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

    // One expected result: gap plus the three status flags
    typedef struct packed {
        logic [SEQ_W-1:0] gap;
        logic             new_source;
        logic             stale;
        logic             table_full;
    } gap_result_t;

    // One directed packet; known_result is used when has_known is set
    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [SEQ_W-1:0] seq;
        logic             has_known;
        gap_result_t      known_result;
    } packet_row_t;

    localparam gap_result_t RES_CLEAN = '{gap: '0, new_source: 1'b0, stale: 1'b0,
                                          table_full: 1'b0};
    localparam gap_result_t RES_NEW   = '{gap: '0, new_source: 1'b1, stale: 1'b0,
                                          table_full: 1'b0};
    localparam gap_result_t RES_STALE = '{gap: '0, new_source: 1'b0, stale: 1'b1,
                                          table_full: 1'b0};
    localparam gap_result_t RES_FULL  = '{gap: '0, new_source: 1'b0, stale: 1'b0,
                                          table_full: 1'b1};
    localparam gap_result_t RES_GAP1  = '{gap: 64'd1, new_source: 1'b0, stale: 1'b0,
                                          table_full: 1'b0};
    localparam gap_result_t RES_TOP   = '{gap: 64'hFFFF_FFFF_FFFF_FFFB, new_source: 1'b0,
                                          stale: 1'b0, table_full: 1'b0};

    localparam int DIRECTED_ROWS = 25;
    localparam packet_row_t DIRECTED [DIRECTED_ROWS] = '{
        // first packet of source 0, then duplicate, in order, one skipped
        '{32'h0000_0000, 64'd0, 1'b1, RES_NEW},
        '{32'h0000_0000, 64'd0, 1'b1, RES_STALE},
        '{32'h0000_0000, 64'd1, 1'b1, RES_CLEAN},
        '{32'h0000_0000, 64'd3, 1'b1, RES_GAP1},
        // jump to the top of the sequence space, then late and equal packets
        '{32'h0000_0000, SEQ_MAX, 1'b1, RES_TOP},
        '{32'h0000_0000, 64'd2, 1'b1, RES_STALE},
        '{32'h0000_0000, SEQ_MAX, 1'b1, RES_STALE},
        '{32'hFFFF_FFFF, SEQ_MAX, 1'b1, RES_NEW},
        '{32'h0000_0001, 64'h5555_5555_5555_5555, 1'b1, RES_NEW},
        '{32'h0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, RES_CLEAN},
        // fill the remaining entries
        '{32'h0000_0002, 64'd0, 1'b1, RES_NEW},
        '{32'h8000_0000, 64'd10, 1'b1, RES_NEW},
        '{32'h7FFF_FFFF, 64'd100, 1'b1, RES_NEW},
        '{32'h5555_5555, 64'd7, 1'b1, RES_NEW},
        '{32'hAAAA_AAAA, 64'd1000, 1'b1, RES_NEW},
        '{32'h0000_0100, 64'd1, 1'b1, RES_NEW},
        '{32'h0001_0000, 64'd42, 1'b1, RES_NEW},
        '{32'h0F0F_0F0F, 64'd5, 1'b1, RES_NEW},
        '{32'hF0F0_F0F0, 64'h0000_0001_0000_0000, 1'b1, RES_NEW},
        '{32'h1234_5678, 64'd3, 1'b1, RES_NEW},
        '{32'h8765_4321, 64'd0, 1'b1, RES_NEW},
        '{32'h0000_0003, 64'd9, 1'b1, RES_NEW},
        '{32'hFFFF_FFFE, 64'd20, 1'b1, RES_NEW},
        // table is now full: unseen source overflows, known source still works
        '{32'h0000_0010, 64'd7, 1'b1, RES_FULL},
        '{32'h0000_0001, 64'hAAAA_AAAA_AAAA_AAAB, 1'b1, RES_CLEAN}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [SRC_W+SEQ_W-1:0] s_axis_tdata;   // stream_id, sequence_req
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [SEQ_W-1:0]       m_axis_tdata;   // gap
    logic [2:0]             m_axis_tuser;   // new_source, stale, table_full

    // Shadow copy of the source table
    logic             seen_valid   [SOURCES];
    logic [SRC_W-1:0] seen_source  [SOURCES];
    logic [SEQ_W-1:0] seen_highest [SOURCES];

    gap_result_t expected_results[$];
    int          error_count = 0;
    bit          no_idle = 1'b0;
    int          ready_hold = 0;

    sequence_gap_tracker_core #(
        .SOURCES(SOURCES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Index of the valid entry holding src, or -1
    function automatic int find_source(input logic [SRC_W-1:0] src);
        for (int i = 0; i < SOURCES; i++)
        begin
            if (seen_valid[i] && seen_source[i] == src)
                return i;
        end
        return -1;
    endfunction

    // Apply one packet to the shadow table and return its result
    task automatic track_packet(input logic [SRC_W-1:0] src, input logic [SEQ_W-1:0] seq,
                                output gap_result_t res);
        int hit;
        int free_slot;
        hit       = find_source(src);
        free_slot = -1;
        for (int i = 0; i < SOURCES; i++)
        begin
            if (!seen_valid[i] && free_slot < 0)
                free_slot = i;
        end
        res = RES_CLEAN;
        if (hit >= 0)
        begin
            if (seq <= seen_highest[hit])
                res.stale = 1'b1;
            else
            begin
                res.gap           = seq - seen_highest[hit] - 64'd1;
                seen_highest[hit] = seq;
            end
        end
        else if (free_slot >= 0)
        begin
            seen_valid[free_slot]   = 1'b1;
            seen_source[free_slot]  = src;
            seen_highest[free_slot] = seq;
            res.new_source          = 1'b1;
        end
        else
            res.table_full = 1'b1;
    endtask

    // Offer one packet, wait for its transfer, queue the expected result
    task automatic send_packet(input logic [SRC_W-1:0] src, input logic [SEQ_W-1:0] seq,
                               input logic has_known, input gap_result_t known_result);
        int          idle_cycles;
        gap_result_t predicted;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            idle_cycles = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (idle_cycles) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {seq, src};
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        track_packet(src, seq, predicted);
        expected_results.insert(expected_results.size(),
                                has_known ? known_result : predicted);
        @(posedge clk);
    endtask

    // Result ready with random stall bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (ready_hold > 0)
        begin
            ready_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            ready_hold = $urandom_range(1, 9) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic void check_field(input string name, input logic [SEQ_W-1:0] exp_val,
                                        input logic [SEQ_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // Result check: signals are stable between the falling and the rising edge
    always @(negedge clk)
    begin
        gap_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got gap %h flags %b",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("gap", want.gap, m_axis_tdata);
                check_field("new_source", 64'(want.new_source), 64'(m_axis_tuser[0]));
                check_field("stale", 64'(want.stale), 64'(m_axis_tuser[1]));
                check_field("table_full", 64'(want.table_full), 64'(m_axis_tuser[2]));
            end
        end
    end

    // Stimulus
    initial
    begin
        int               mode;
        int               slot;
        logic [SRC_W-1:0] src;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] top;
        logic [SEQ_W-1:0] step;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        for (int i = 0; i < SOURCES; i++)
        begin
            seen_valid[i]   = 1'b0;
            seen_source[i]  = '0;
            seen_highest[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_packet(DIRECTED[r].src, DIRECTED[r].seq, DIRECTED[r].has_known,
                        DIRECTED[r].known_result);

        // Random phase on a full table: mostly traffic on stored sources
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                no_idle = 1'b1;
            if (n == DRAIN_PAUSE_AT)
            begin
                s_axis_tvalid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
            mode = $urandom_range(0, 99);
            slot = $urandom_range(0, SOURCES - 1);
            src  = seen_source[slot];
            top  = seen_highest[slot];
            if (mode < 40)
            begin
                // next in order; a source at the top can only repeat
                seq = (top == SEQ_MAX) ? top : top + 64'd1;
            end
            else if (mode < 65)
            begin
                // up to 1001 packets lost
                step = 64'd2 + 64'($urandom_range(0, 1000));
                seq  = (top > SEQ_MAX - step) ? SEQ_MAX : top + step;
            end
            else if (mode < 80)
            begin
                // duplicate or late packet
                step = 64'($urandom_range(0, 1000));
                seq  = (top >= step) ? top - step : '0;
            end
            else if (mode < 85)
            begin
                // long outage
                step = {$urandom(), $urandom()} >> $urandom_range(16, 62);
                seq  = (top >= SEQ_MAX - step) ? SEQ_MAX : top + step + 64'd1;
            end
            else
            begin
                // unseen source overflows the table
                do
                    src = $urandom();
                while (find_source(src) >= 0);
                seq = {$urandom(), $urandom()};
            end
            send_packet(src, seq, 1'b0, RES_CLEAN);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: sequence_gap_tracker_core.f
rtl/sgt_pkg.sv
rtl/sgt_table.sv
rtl/sequence_gap_tracker_core.sv
tb/sequence_gap_tracker_core_test.sv
